@@ rtl/slidm_pkg.sv @@
package slidm_pkg;

    // List capacity, data and field widths, and the widths that follow from the capacity.
    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int POS_W     = 7;
    localparam int OUT_CNT_W = 7;
    // Width wide enough to compare a position against count + 1.
    localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Operation codes.
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_DEL_MIN = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic ins_rd;
        logic del_rd;
        logic ins_put;
        logic del_put;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ins_ok;
        logic del_ok;
        logic no_shift;
        logic rd_end;
    } t_stat;

endpackage

@@ rtl/slidm_ram.sv @@
module slidm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/slidm_ctrl.sv @@
module slidm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_op,
    input  logic           i_stall,
    input  slidm_pkg::t_stat i_stat,
    output logic           o_stall,
    output logic           o_valid,
    output slidm_pkg::t_cmd  o_cmd
);
    import slidm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_DRAIN,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_DRAIN,
        S_DEL_PUT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   w_cmd;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.accept = 1'b1;
                    if (i_op == OP_DEL_MIN) begin
                        n_state = i_stat.del_ok ? S_DEL_RD : S_DONE;
                    end else if (!i_stat.ins_ok) begin
                        n_state = S_DONE;
                    end else if (i_stat.no_shift) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_state = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                w_cmd.ins_rd = 1'b1;
                if (i_stat.rd_end) begin
                    n_state = S_INS_DRAIN;
                end
            end
            S_INS_DRAIN: begin
                n_state = S_INS_PUT;
            end
            S_INS_PUT: begin
                w_cmd.ins_put = 1'b1;
                n_state       = S_DONE;
            end
            S_DEL_RD: begin
                w_cmd.del_rd = 1'b1;
                if (i_stat.rd_end) begin
                    n_state = S_DEL_DRAIN;
                end
            end
            S_DEL_DRAIN: begin
                n_state = S_DEL_PUT;
            end
            S_DEL_PUT: begin
                w_cmd.del_put = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The output register stays full until the item is taken.
    always_comb begin
        if (w_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

endmodule

@@ rtl/slidm_dp.sv @@
module slidm_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  slidm_pkg::t_cmd                      i_cmd,
    input  logic                                 i_op,
    input  logic [slidm_pkg::POS_W-1:0]          i_position,
    input  logic signed [slidm_pkg::DATA_W-1:0]  i_item_value,
    output slidm_pkg::t_stat                     o_stat,
    output logic                                 o_ok,
    output logic signed [slidm_pkg::DATA_W-1:0]  o_min_value,
    output logic [slidm_pkg::OUT_CNT_W-1:0]      o_entry_count
);
    import slidm_pkg::*;

    logic [CNT_W-1:0]         r_count;
    logic                     r_is_del;
    logic                     r_ok;
    logic signed [DATA_W-1:0] r_val;
    logic [ADDR_W-1:0]        r_pos_idx;
    logic [ADDR_W-1:0]        r_rd_addr;
    logic                     r_pend;
    logic [ADDR_W-1:0]        r_pend_addr;
    logic signed [DATA_W-1:0] r_best;
    logic [ADDR_W-1:0]        r_where;
    logic [DATA_W-1:0]        r_last;
    logic                     r_out_ok;
    logic signed [DATA_W-1:0] r_out_min;
    logic [OUT_CNT_W-1:0]     r_out_cnt;

    logic [CMP_W-1:0]  w_pos_ext;
    logic [CMP_W-1:0]  w_cnt_inc;
    logic [ADDR_W-1:0] w_last_idx;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [DATA_W-1:0] w_rdata;
    t_stat             w_stat;

    // Acceptance checks and scan end detection.
    always_comb begin
        w_pos_ext       = CMP_W'(i_position);
        w_cnt_inc       = CMP_W'(r_count) + CMP_W'(1);
        w_last_idx      = ADDR_W'(r_count - CNT_W'(1));
        w_stat.ins_ok   = (w_pos_ext != '0) && (w_pos_ext <= w_cnt_inc)
                          && (r_count < CNT_W'(DEPTH));
        w_stat.del_ok   = (r_count != '0);
        w_stat.no_shift = (w_pos_ext == w_cnt_inc);
        w_stat.rd_end   = r_is_del ? (r_rd_addr == w_last_idx)
                                   : (r_rd_addr == r_pos_idx);
    end

    // Write port: shifted entry, new value, or last entry into the hole.
    always_comb begin
        w_we = (r_pend && !r_is_del) || i_cmd.ins_put || i_cmd.del_put;
        if (i_cmd.ins_put) begin
            w_waddr = r_pos_idx;
            w_wdata = r_val;
        end else if (i_cmd.del_put) begin
            w_waddr = r_where;
            w_wdata = r_last;
        end else begin
            w_waddr = r_pend_addr + ADDR_W'(1);
            w_wdata = w_rdata;
        end
    end

    slidm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    // Control-side registers that need reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= i_cmd.ins_rd || i_cmd.del_rd;
            if (i_cmd.ins_put) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.del_put) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Item operands, address walk, minimum tracking and result payload.
    always_ff @(posedge i_clk) begin
        r_pend_addr <= r_rd_addr;
        if (i_cmd.accept) begin
            r_is_del  <= (i_op == OP_DEL_MIN);
            r_val     <= i_item_value;
            r_pos_idx <= ADDR_W'(w_pos_ext - CMP_W'(1));
            r_ok      <= (i_op == OP_DEL_MIN) ? w_stat.del_ok : w_stat.ins_ok;
            r_rd_addr <= (i_op == OP_DEL_MIN) ? '0 : w_last_idx;
        end else if (i_cmd.ins_rd) begin
            r_rd_addr <= r_rd_addr - ADDR_W'(1);
        end else if (i_cmd.del_rd) begin
            r_rd_addr <= r_rd_addr + ADDR_W'(1);
        end
        if (r_pend && r_is_del) begin
            r_last <= w_rdata;
            if ((r_pend_addr == '0) || ($signed(w_rdata) < r_best)) begin
                r_best  <= $signed(w_rdata);
                r_where <= r_pend_addr;
            end
        end
        if (i_cmd.load_out) begin
            r_out_ok  <= r_ok;
            r_out_min <= (r_ok && r_is_del) ? r_best : '0;
            r_out_cnt <= OUT_CNT_W'(r_count);
        end
    end

    assign o_stat        = w_stat;
    assign o_ok          = r_out_ok;
    assign o_min_value   = r_out_min;
    assign o_entry_count = r_out_cnt;

endmodule

@@ rtl/sequential_list_insert_delete_min.sv @@
// Channel | Handshake          | Payload
// input   | i_valid / o_stall  | i_op, i_position, i_item_value
// result  | o_valid / i_stall  | o_ok, o_min_value, o_entry_count
//
// Insert shifts the entries from the position to the end up by one, then writes the
// new value; an append writes it directly. Delete-min scans every entry, then moves
// the last entry into the slot of the minimum; rejected items do neither. The list
// memory has a single read port, so one entry is moved or scanned per cycle.
// Reset empties the list; the memory itself is not cleared.
// A new item is taken while the previous result waits in the output register.
module sequential_list_insert_delete_min (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_op,
    input  logic [slidm_pkg::POS_W-1:0]          i_position,
    input  logic signed [slidm_pkg::DATA_W-1:0]  i_item_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_ok,
    output logic signed [slidm_pkg::DATA_W-1:0]  o_min_value,
    output logic [slidm_pkg::OUT_CNT_W-1:0]      o_entry_count
);
    import slidm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer.
    slidm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    // List storage, count and scan datapath.
    slidm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_stat        (w_stat),
        .o_ok          (o_ok),
        .o_min_value   (o_min_value),
        .o_entry_count (o_entry_count)
    );

endmodule

@@ rtl/slidm_checker.sv @@
module slidm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic                                 o_ok,
    input logic signed [slidm_pkg::DATA_W-1:0]  o_min_value,
    input logic [slidm_pkg::OUT_CNT_W-1:0]      o_entry_count
);
    import slidm_pkg::*;

    // A result waiting under stall keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ok)
            && $stable(o_min_value) && $stable(o_entry_count))
        else $error("stalled result changed");

    // A rejected operation reports a zero minimum.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_min_value == '0)
        else $error("rejected item with nonzero minimum");

    // The reported count never exceeds the capacity.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> int'(o_entry_count) <= DEPTH)
        else $error("entry count above capacity");

    // Reset leaves no result pending and the input ready.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("state not cleared by reset");

    // An item accepted on an idle block is never answered in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result appeared too early");

endmodule

bind sequential_list_insert_delete_min slidm_checker u_slidm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_ok          (o_ok),
    .o_min_value   (o_min_value),
    .o_entry_count (o_entry_count)
);
